[rtl/bdq_pkg.sv]
// ----------------------------------------------------------------------------
// bdq_pkg
// shared types and constants for the bounded deque with insert
// ----------------------------------------------------------------------------
`default_nettype none

package bdq_pkg;

	localparam int VAL_W     = 32;
	localparam int POS_W     = 8;
	localparam int IDX_W     = 8;
	localparam int CNT_OUT_W = 5;
	localparam int DEPTH_DEF = 16;

	typedef enum logic [2:0] {
		REQ_APPEND    = 3'd0,
		REQ_PREPEND   = 3'd1,
		REQ_DROP_TAIL = 3'd2,
		REQ_DROP_HEAD = 3'd3,
		REQ_INSERT    = 3'd4
	} req_t;

	typedef enum logic [1:0] {
		ST_DONE  = 2'd0,
		ST_EMPTY = 2'd1,
		ST_FULL  = 2'd2
	} status_t;

	// command broadcast to every cell of the chain
	typedef struct packed {
		logic             ins;
		logic             popf;
		logic [IDX_W-1:0] k;
		logic [IDX_W-1:0] sel;
	} cell_cmd_t;

endpackage

`default_nettype wire

[rtl/bdq_cell.sv]
// ----------------------------------------------------------------------------
// bdq_cell
// one storage cell of the deque chain: holds, shifts from a neighbour or loads
// ----------------------------------------------------------------------------
`default_nettype none

module bdq_cell #(
	parameter int IDX = 0
) (
	input  wire                           clk,
	input  wire  bdq_pkg::cell_cmd_t      cmd,
	input  wire  [bdq_pkg::VAL_W-1:0]     in_value,
	input  wire  [bdq_pkg::VAL_W-1:0]     left_value,
	input  wire  [bdq_pkg::VAL_W-1:0]     right_value,
	output logic [bdq_pkg::VAL_W-1:0]     value,
	output logic [bdq_pkg::VAL_W-1:0]     tap
);

	localparam logic [bdq_pkg::IDX_W-1:0] IDX_B = bdq_pkg::IDX_W'(IDX);

	logic [bdq_pkg::VAL_W-1:0] value_q;

	always_ff @(posedge clk) begin
		if (cmd.ins) begin
			if (IDX_B == cmd.k) begin
				value_q <= in_value;
			end else if (IDX_B > cmd.k) begin
				value_q <= left_value;
			end
		end else if (cmd.popf) begin
			value_q <= right_value;
		end
	end

	assign value = value_q;
	assign tap   = (IDX_B == cmd.sel) ? value_q : '0;

endmodule

`default_nettype wire

[rtl/bounded_deque_with_insert_core.sv]
// ----------------------------------------------------------------------------
// bounded_deque_with_insert_core
// bounded double-ended queue of signed values with positional insert
// ----------------------------------------------------------------------------
//  channel   dir  payload
//  s_axis    in   tdata: item_value, insert_position; tuser: req_type
//  m_axis    out  tdata: front_value, back_value, element_count; tuser: status
//
//  the cell chain shifts or loads at the accepting edge; the front/back taps
//  are registered on the next edge and the result is offered from then on
//  s_axis_tready stays low from acceptance until the result has been taken,
//  so a new transaction is accepted only after the previous result has left
//  m_axis; an m_axis stall holds off the next acceptance
//  reset clears the count and control; cell contents are not reset
// ----------------------------------------------------------------------------
`default_nettype none

module bounded_deque_with_insert_core #(
	parameter int DEPTH = bdq_pkg::DEPTH_DEF
) (
	input  wire         clk,
	input  wire         arst_n,
	input  wire         s_axis_tvalid,
	output logic        s_axis_tready,
	input  wire  [39:0] s_axis_tdata,   // item_value[31:0], insert_position[39:32]
	input  wire  [2:0]  s_axis_tuser,   // req_type[2:0]
	output logic        m_axis_tvalid,
	input  wire         m_axis_tready,
	output logic [71:0] m_axis_tdata,   // front_value[31:0], back_value[63:32],
	                                    // element_count[68:64], zero pad
	output logic [1:0]  m_axis_tuser    // status[1:0]
);

	localparam int CW = $clog2(DEPTH + 1);
	localparam int VW = bdq_pkg::VAL_W;
	localparam int IW = bdq_pkg::IDX_W;

	logic [CW-1:0]           count_q;
	logic                    busy_q;
	logic                    out_valid_q;
	bdq_pkg::status_t        status_q;
	logic [VW-1:0]           front_q;
	logic [VW-1:0]           back_q;
	logic [CW-1:0]           count_out_q;
	bdq_pkg::status_t        status_out_q;

	logic                    accept;
	bdq_pkg::req_t           req;
	logic [VW-1:0]           in_value;
	logic [bdq_pkg::POS_W-1:0] pos;
	logic                    full;
	logic                    empty;
	logic                    is_push;
	logic                    is_pop;
	logic [IW-1:0]           k;
	bdq_pkg::cell_cmd_t      cmd;
	logic [CW-1:0]           count_d;
	bdq_pkg::status_t        status_d;
	logic [VW-1:0]           back_or;

	logic [VW-1:0] cell_value [DEPTH];
	logic [VW-1:0] cell_tap   [DEPTH];

	assign accept   = s_axis_tvalid && s_axis_tready;
	assign req      = bdq_pkg::req_t'(s_axis_tuser);
	assign in_value = s_axis_tdata[31:0];
	assign pos      = s_axis_tdata[39:32];
	assign full     = (count_q == CW'(DEPTH));
	assign empty    = (count_q == '0);
	assign is_push  = (req == bdq_pkg::REQ_APPEND) || (req == bdq_pkg::REQ_PREPEND) ||
	                  (req == bdq_pkg::REQ_INSERT);
	assign is_pop   = (req == bdq_pkg::REQ_DROP_TAIL) || (req == bdq_pkg::REQ_DROP_HEAD);

	// target slot of a push or insert
	always_comb begin
		k = IW'(count_q);
		case (req)
			bdq_pkg::REQ_APPEND:  k = IW'(count_q);
			bdq_pkg::REQ_PREPEND: k = '0;
			bdq_pkg::REQ_INSERT: begin
				if (pos <= 8'd1) begin
					k = '0;
				end else if (9'(pos) > 9'(count_q)) begin
					k = IW'(count_q);
				end else begin
					k = IW'(pos - 8'd1);
				end
			end
			default: k = IW'(count_q);
		endcase
	end

	always_comb begin
		count_d  = count_q;
		status_d = bdq_pkg::ST_DONE;
		if (is_push) begin
			if (full) begin
				status_d = bdq_pkg::ST_FULL;
			end else begin
				count_d = count_q + 1'b1;
			end
		end else if (is_pop) begin
			if (empty) begin
				status_d = bdq_pkg::ST_EMPTY;
			end else begin
				count_d = count_q - 1'b1;
			end
		end
	end

	always_comb begin
		cmd.ins  = accept && is_push && !full;
		cmd.popf = accept && (req == bdq_pkg::REQ_DROP_HEAD) && !empty;
		cmd.k    = k;
		cmd.sel  = IW'(count_q - 1'b1);
	end

	genvar gi;
	generate
		for (gi = 0; gi < DEPTH; gi++) begin : g_cell
			bdq_cell #(
				.IDX (gi)
			) u_cell (
				.clk         (clk),
				.cmd         (cmd),
				.in_value    (in_value),
				.left_value  (cell_value[(gi == 0) ? 0 : gi - 1]),
				.right_value (cell_value[(gi == DEPTH - 1) ? gi : gi + 1]),
				.value       (cell_value[gi]),
				.tap         (cell_tap[gi])
			);
		end
	endgenerate

	always_comb begin
		back_or = '0;
		for (int i = 0; i < DEPTH; i++) begin
			back_or = back_or | cell_tap[i];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q     <= '0;
			busy_q      <= 1'b0;
			out_valid_q <= 1'b0;
			status_q    <= bdq_pkg::ST_DONE;
		end else begin
			if (accept) begin
				count_q  <= count_d;
				status_q <= status_d;
				busy_q   <= 1'b1;
			end else if (busy_q) begin
				busy_q      <= 1'b0;
				out_valid_q <= 1'b1;
			end else if (out_valid_q && m_axis_tready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (busy_q) begin
			front_q      <= empty ? '0 : cell_value[0];
			back_q       <= empty ? '0 : back_or;
			count_out_q  <= count_q;
			status_out_q <= status_q;
		end
	end

	assign s_axis_tready = !busy_q && !out_valid_q;
	assign m_axis_tvalid = out_valid_q;
	assign m_axis_tdata  = {3'b000, bdq_pkg::CNT_OUT_W'(count_out_q), back_q, front_q};
	assign m_axis_tuser  = status_out_q;

	a_one_in_flight: assert property (@(posedge clk) disable iff (!arst_n)
		!(busy_q && out_valid_q))
		else $error("work stage and output stage both occupied");

	a_accept_starts_work: assert property (@(posedge clk) disable iff (!arst_n)
		accept |=> busy_q && !out_valid_q)
		else $error("accepted transaction did not enter work stage");

	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= CW'(DEPTH))
		else $error("element count above depth");

	a_count_step: assert property (@(posedge clk) disable iff (!arst_n)
		!$past(accept) |-> $stable(count_q))
		else $error("count moved without a transaction");

endmodule

`default_nettype wire

[sim/tb.sv]
// ----------------------------------------------------------------------------
// tb
// self-checking bench for bounded_deque_with_insert_core: a queue-based
// predictor tracks the deque contents, every request transaction is
// predicted on acceptance and each result transaction is checked against
// the oldest prediction, under phases of sender gaps and receiver stalls
// ----------------------------------------------------------------------------
`default_nettype none

module tb;

	localparam int          DEPTH       = bdq_pkg::DEPTH_DEF;
	localparam int          PHASE_ITEMS = 360;
	localparam logic [2:0]  REQ_BAD_LO  = 3'd5;
	localparam logic [2:0]  REQ_BAD_HI  = 3'd7;
	localparam logic [31:0] VAL_MAX     = 32'h7fff_ffff;
	localparam logic [31:0] VAL_MIN     = 32'h8000_0000;

	typedef struct {
		logic [2:0]                req_type;
		logic [bdq_pkg::VAL_W-1:0] item_value;
		logic [bdq_pkg::POS_W-1:0] insert_position;
	} deq_req_t;

	typedef struct {
		logic [bdq_pkg::VAL_W-1:0]     front_value;
		logic [bdq_pkg::VAL_W-1:0]     back_value;
		logic [bdq_pkg::CNT_OUT_W-1:0] element_count;
		logic [1:0]                    status;
	} deq_view_t;

	logic        clk           = 1'b0;
	logic        arst_n        = 1'b0;
	logic        s_axis_tvalid = 1'b0;
	wire         s_axis_tready;
	logic [39:0] s_axis_tdata  = '0;
	logic [2:0]  s_axis_tuser  = '0;
	wire         m_axis_tvalid;
	logic        m_axis_tready = 1'b0;
	wire  [71:0] m_axis_tdata;
	wire  [1:0]  m_axis_tuser;

	deq_req_t                  pending_reqs[$];
	deq_view_t                 expected_views[$];
	logic [bdq_pkg::VAL_W-1:0] deq_contents[$];

	int n_issued      = 0;
	int n_taken       = 0;
	int n_errors      = 0;
	int src_idle_pct  = 0;
	int snk_stall_pct = 0;
	bit hold_src      = 1'b0;

	bounded_deque_with_insert_core #(
		.DEPTH(DEPTH)
	) i_dut (
		.clk           (clk),
		.arst_n        (arst_n),
		.s_axis_tvalid (s_axis_tvalid),
		.s_axis_tready (s_axis_tready),
		.s_axis_tdata  (s_axis_tdata),
		.s_axis_tuser  (s_axis_tuser),
		.m_axis_tvalid (m_axis_tvalid),
		.m_axis_tready (m_axis_tready),
		.m_axis_tdata  (m_axis_tdata),
		.m_axis_tuser  (m_axis_tuser)
	);

	always #5 clk = ~clk;

	function automatic deq_view_t deq_apply(deq_req_t r);
		deq_view_t v;
		int unsigned n;
		n = deq_contents.size();
		v.status = bdq_pkg::ST_DONE;
		case (r.req_type)
		bdq_pkg::REQ_APPEND, bdq_pkg::REQ_PREPEND, bdq_pkg::REQ_INSERT: begin
			if (n >= DEPTH)
				v.status = bdq_pkg::ST_FULL;
			else if (r.req_type == bdq_pkg::REQ_APPEND ||
			         (r.req_type == bdq_pkg::REQ_INSERT && r.insert_position > n))
				deq_contents = {deq_contents, r.item_value};
			else if (r.req_type == bdq_pkg::REQ_PREPEND || r.insert_position <= 1)
				deq_contents = {r.item_value, deq_contents};
			else
				deq_contents.insert(r.insert_position - 1, r.item_value);
		end
		bdq_pkg::REQ_DROP_TAIL, bdq_pkg::REQ_DROP_HEAD: begin
			if (n == 0)
				v.status = bdq_pkg::ST_EMPTY;
			else if (r.req_type == bdq_pkg::REQ_DROP_TAIL)
				deq_contents.delete(n - 1);
			else
				deq_contents.delete(0);
		end
		default: ;
		endcase
		n = deq_contents.size();
		v.front_value   = (n > 0) ? deq_contents[0] : '0;
		v.back_value    = (n > 0) ? deq_contents[n-1] : '0;
		v.element_count = bdq_pkg::CNT_OUT_W'(n);
		return v;
	endfunction

	task automatic add_req(input logic [2:0] kind, input logic [bdq_pkg::VAL_W-1:0] val,
	                       input logic [bdq_pkg::POS_W-1:0] pos);
		deq_req_t r;
		r.req_type        = kind;
		r.item_value      = val;
		r.insert_position = pos;
		pending_reqs = {pending_reqs, r};
	endtask

	function automatic logic [bdq_pkg::VAL_W-1:0] pick_value();
		case ($urandom_range(0, 9))
		0:       return VAL_MAX;
		1:       return VAL_MIN;
		2:       return '0;
		3:       return '1;
		default: return $urandom();
		endcase
	endfunction

	// bursts that lean towards growing or shrinking, or stay balanced, so full and empty are both hit
	task automatic add_random(input int n);
		int mode;
		int len;
		int roll;
		logic [2:0] kind;
		logic [bdq_pkg::POS_W-1:0] pos;
		while (n > 0) begin
			mode = $urandom_range(0, 2);
			len  = $urandom_range(8, 40);
			for (int i = 0; i < len && n > 0; i++) begin
				roll = $urandom_range(0, 99);
				if (roll < 3)
					kind = 3'($urandom_range(REQ_BAD_LO, REQ_BAD_HI));
				else if ((mode == 0 && roll < 78) || (mode == 1 && roll < 25) ||
				         (mode == 2 && roll < 51))
					case ($urandom_range(0, 2))
					0:       kind = bdq_pkg::REQ_APPEND;
					1:       kind = bdq_pkg::REQ_PREPEND;
					default: kind = bdq_pkg::REQ_INSERT;
					endcase
				else
					kind = $urandom_range(0, 1) ? bdq_pkg::REQ_DROP_TAIL :
					                              bdq_pkg::REQ_DROP_HEAD;
				if ($urandom_range(0, 99) < 85)
					pos = bdq_pkg::POS_W'($urandom_range(0, DEPTH + 2));
				else
					pos = bdq_pkg::POS_W'($urandom_range(0, 255));
				add_req(kind, pick_value(), pos);
				n--;
			end
		end
	endtask

	task automatic wait_drained();
		while (pending_reqs.size() != 0 || n_taken != n_issued || expected_views.size() != 0)
			@(posedge clk);
	endtask

	task automatic run_phase(input int src_pct, input int snk_pct, input bit do_hold);
		@(posedge clk);
		src_idle_pct  = src_pct;
		snk_stall_pct = snk_pct;
		add_random(PHASE_ITEMS);
		if (do_hold) begin
			while (pending_reqs.size() > PHASE_ITEMS / 2)
				@(posedge clk);
			hold_src = 1'b1;
			while (n_taken != n_issued || expected_views.size() != 0)
				@(posedge clk);
			hold_src = 1'b0;
		end
		wait_drained();
	endtask

	// request driver
	always @(negedge clk) begin : drive
		deq_req_t nxt;
		if (arst_n && n_taken == n_issued) begin
			if (pending_reqs.size() != 0 && !hold_src &&
			    $urandom_range(0, 99) >= src_idle_pct) begin
				nxt = pending_reqs[0];
				pending_reqs.delete(0);
				s_axis_tdata  <= {nxt.insert_position, nxt.item_value};
				s_axis_tuser  <= nxt.req_type;
				s_axis_tvalid <= 1'b1;
				n_issued      <= n_issued + 1;
			end else begin
				s_axis_tvalid <= 1'b0;
			end
		end
	end

	always @(negedge clk)
		m_axis_tready <= ($urandom_range(0, 99) >= snk_stall_pct);

	// result checker and request predictor
	always @(posedge clk) begin : watch
		deq_view_t exp_v;
		deq_req_t  got_r;
		if (arst_n && m_axis_tvalid && m_axis_tready) begin
			if (expected_views.size() == 0) begin
				$error("result transaction with no request outstanding");
				n_errors++;
			end else begin
				exp_v = expected_views[0];
				expected_views.delete(0);
				if (m_axis_tdata[31:0] !== exp_v.front_value) begin
					$error("front_value: expected %0d, got %0d",
					       $signed(exp_v.front_value), $signed(m_axis_tdata[31:0]));
					n_errors++;
				end
				if (m_axis_tdata[63:32] !== exp_v.back_value) begin
					$error("back_value: expected %0d, got %0d",
					       $signed(exp_v.back_value), $signed(m_axis_tdata[63:32]));
					n_errors++;
				end
				if (m_axis_tdata[68:64] !== exp_v.element_count) begin
					$error("element_count: expected %0d, got %0d",
					       exp_v.element_count, m_axis_tdata[68:64]);
					n_errors++;
				end
				if (m_axis_tuser !== exp_v.status) begin
					$error("status: expected %0d, got %0d", exp_v.status, m_axis_tuser);
					n_errors++;
				end
			end
		end
		if (arst_n && s_axis_tvalid && s_axis_tready) begin
			got_r.item_value      = s_axis_tdata[31:0];
			got_r.insert_position = s_axis_tdata[39:32];
			got_r.req_type        = s_axis_tuser;
			expected_views = {expected_views, deq_apply(got_r)};
			n_taken <= n_taken + 1;
		end
	end

	initial begin
		#2000000;
		$display("CHECK FAILED");
		$finish;
	end

	initial begin
		repeat (10) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		// empty pops, inserts at every kind of position, extremes, unknown kinds
		add_req(bdq_pkg::REQ_DROP_TAIL, 32'd1,   8'd0);
		add_req(bdq_pkg::REQ_DROP_HEAD, 32'd2,   8'd0);
		add_req(bdq_pkg::REQ_INSERT,    32'd7,   8'd255);
		add_req(bdq_pkg::REQ_APPEND,    VAL_MAX, 8'd0);
		add_req(bdq_pkg::REQ_PREPEND,   VAL_MIN, 8'd255);
		add_req(bdq_pkg::REQ_INSERT,    32'd11,  8'd0);
		add_req(bdq_pkg::REQ_INSERT,    32'd12,  8'd1);
		add_req(bdq_pkg::REQ_INSERT,    32'd13,  8'd2);
		add_req(bdq_pkg::REQ_INSERT,    32'd14,  8'd6);
		add_req(bdq_pkg::REQ_INSERT,    32'd15,  8'd8);
		add_req(REQ_BAD_LO,             '1,      '1);
		add_req(REQ_BAD_HI,             '1,      '1);
		add_req(REQ_BAD_LO + 3'd1,      32'd3,   8'd3);
		add_req(bdq_pkg::REQ_DROP_HEAD, '1,      '1);
		add_req(bdq_pkg::REQ_DROP_TAIL, '1,      '1);
		add_req(bdq_pkg::REQ_APPEND,    '0,      8'd0);
		add_req(bdq_pkg::REQ_APPEND,    '1,      8'd0);
		add_req(bdq_pkg::REQ_INSERT,    '1,      8'd3);
		add_req(bdq_pkg::REQ_INSERT,    VAL_MIN, 8'd7);
		wait_drained();

		run_phase(0, 0, 1'b0);
		run_phase(46, 0, 1'b1);
		run_phase(0, 46, 1'b0);
		run_phase(6, 6, 1'b0);

		repeat (10) @(posedge clk);
		if (n_errors == 0 && expected_views.size() == 0) begin
			$display("CHECK OK");
		end else begin
			if (expected_views.size() != 0)
				$error("%0d expected results never arrived", expected_views.size());
			$display("CHECK FAILED");
		end
		$finish;
	end

endmodule

`default_nettype wire

[filelist.f]
rtl/bdq_pkg.sv
rtl/bdq_cell.sv
rtl/bounded_deque_with_insert_core.sv
sim/tb.sv
